// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

    localparam int GAIN_W      = 32;
    localparam int LIMIT_W     = 31;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    // wide enough for +/- 2^61 terms and their three-way sum
    localparam int TERM_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic signed [TERM_W-1:0] term_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] value;
        logic                     hit;
    } clamp_t;

    // load strobes for the two register stages inside a term unit
    typedef struct packed {
        logic load_mul;
        logic load_scale;
    } term_ctrl_t;

    function automatic clamp_t clamp_sym(term_t v, term_t lim);
        clamp_t r;
        r.value = v;
        r.hit   = 1'b0;
        if (v > lim)
        begin
            r.value = lim;
            r.hit   = 1'b1;
        end
        else if (v < -lim)
        begin
            r.value = -lim;
            r.hit   = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pidc_term.sv =====
module pidc_term #(
    parameter int DATA_WIDTH = 32,
    parameter int SHIFT      = 16
) (
    input  logic                            clk,
    input  pidc_pkg::term_ctrl_t            ctrl,
    input  logic signed [DATA_WIDTH:0]      operand,
    input  logic [pidc_pkg::GAIN_W-1:0]     gain,
    output pidc_pkg::term_t                 term
);

    localparam int OPW = DATA_WIDTH + 1;
    localparam int MW  = OPW + pidc_pkg::GAIN_W + 1;
    localparam int XW  = (MW > 64) ? MW : 64;

    localparam logic signed [XW-1:0] SAT_POS = {{(XW-62){1'b0}}, 1'b1, {61{1'b0}}};
    localparam logic signed [XW-1:0] SAT_NEG = -SAT_POS;

    logic signed [MW-1:0]   prod_reg;
    logic signed [MW-1:0]   prod_next;
    logic signed [MW-1:0]   shifted;
    logic signed [XW-1:0]   shifted_ext;
    pidc_pkg::term_t        term_reg;
    pidc_pkg::term_t        term_next;

    assign prod_next   = MW'(operand) * MW'($signed({1'b0, gain}));
    // arithmetic shift floors toward minus infinity
    assign shifted     = prod_reg >>> SHIFT;
    assign shifted_ext = XW'(shifted);

    always_comb
    begin
        if (shifted_ext > SAT_POS)
            term_next = pidc_pkg::TERM_W'(SAT_POS);
        else if (shifted_ext < SAT_NEG)
            term_next = pidc_pkg::TERM_W'(SAT_NEG);
        else
            term_next = pidc_pkg::TERM_W'(shifted_ext);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
            prod_reg <= prod_next;
        if (ctrl.load_scale)
            term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

// ===== rtl/pidc_integ.sv =====
module pidc_integ #(
    parameter int DATA_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             clear,
    input  pidc_pkg::term_t  step,
    input  pidc_pkg::term_t  limit,
    output pidc_pkg::term_t  integ,
    output logic             hit
);

    logic signed [DATA_WIDTH-1:0] store_reg;
    logic signed [DATA_WIDTH-1:0] store_next;
    pidc_pkg::term_t              sum;
    pidc_pkg::clamp_t             clamped;
    pidc_pkg::term_t              integ_reg;
    logic                         hit_reg;

    assign sum        = pidc_pkg::TERM_W'(store_reg) + step;
    assign clamped    = pidc_pkg::clamp_sym(sum, limit);
    assign store_next = clear ? '0 : clamped.value[DATA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
        end
        else if (load)
        begin
            store_reg <= store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            integ_reg <= clear ? '0 : clamped.value;
            hit_reg   <= clear ? 1'b0 : clamped.hit;
        end
    end

    assign integ = integ_reg;
    assign hit   = hit_reg;

endmodule

// ===== rtl/pid_controller_trapezoid_clamped.sv =====
// One-channel PID controller in signed fixed point (DATA_WIDTH bits, FRAC_BITS
// fraction bits) with clamped trapezoid integration and a clamped output. The
// block takes one beat per cycle while in_stall is low and returns one result
// beat per input beat, in order; an output stall backs the pipeline up
// stage by stage and holds off the input only once every stage is full.
// The pipeline stages are, in order: input register, gain multiply, scale
// and saturate, integral accumulate and clamp, output sum and clamp. The
// integral store closes its loop within one stage, so back-to-back updates
// need no forwarding. A clear command zeroes the stored error and integral
// and returns a zero result.
module pid_controller_trapezoid_clamped #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 wr_en,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]      wr_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [DATA_WIDTH-1:0]         error_sample,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [DATA_WIDTH-1:0]         drive_value,
    output logic                                 integral_clamped,
    output logic                                 output_clamped
);

    localparam pidc_pkg::term_t DATA_MAX =
        pidc_pkg::TERM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);

    // configuration
    logic [pidc_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic [pidc_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic [pidc_pkg::GAIN_W-1:0]  deriv_gain_reg;
    logic [pidc_pkg::LIMIT_W-1:0] integral_limit_reg;
    logic [pidc_pkg::LIMIT_W-1:0] output_limit_reg;

    // pipeline control
    logic valid0_reg, valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic clear0_reg, clear1_reg, clear2_reg, clear3_reg;
    logic ready0, ready1, ready2, ready3, ready4;
    logic accept;

    // input stage
    logic signed [DATA_WIDTH-1:0] last_error_reg;
    logic signed [DATA_WIDTH:0]   error_ext;
    logic signed [DATA_WIDTH:0]   last_ext;
    logic signed [DATA_WIDTH:0]   err0_reg;
    logic signed [DATA_WIDTH:0]   sum0_reg;
    logic signed [DATA_WIDTH:0]   diff0_reg;

    pidc_pkg::term_ctrl_t term_ctrl;
    pidc_pkg::term_t      prop_term;
    pidc_pkg::term_t      step_term;
    pidc_pkg::term_t      deriv_term;

    pidc_pkg::term_t      integ_lim;
    pidc_pkg::term_t      output_lim;
    pidc_pkg::term_t      integ_lim_raw;
    pidc_pkg::term_t      output_lim_raw;
    pidc_pkg::term_t      integ_val;
    logic                 integ_hit;
    pidc_pkg::term_t      pd3_reg;

    pidc_pkg::term_t      total;
    pidc_pkg::clamp_t     total_clamped;

    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic                         iflag_reg;
    logic                         oflag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            integral_limit_reg <= '1;
            output_limit_reg   <= '1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                pidc_pkg::REG_PROP_GAIN:
                    prop_gain_reg <= wr_data;
                pidc_pkg::REG_INTEG_GAIN:
                    integ_gain_reg <= wr_data;
                pidc_pkg::REG_DERIV_GAIN:
                    deriv_gain_reg <= wr_data;
                pidc_pkg::REG_INTEGRAL_LIMIT:
                    integral_limit_reg <= wr_data[pidc_pkg::LIMIT_W-1:0];
                pidc_pkg::REG_OUTPUT_LIMIT:
                    output_limit_reg <= wr_data[pidc_pkg::LIMIT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // a stage may load when it is empty or its occupant moves on
    assign ready4   = !valid4_reg || !out_stall;
    assign ready3   = !valid3_reg || ready4;
    assign ready2   = !valid2_reg || ready3;
    assign ready1   = !valid1_reg || ready2;
    assign ready0   = !valid0_reg || ready1;
    assign in_stall = !ready0;
    assign accept   = in_valid && ready0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg     <= 1'b0;
            valid1_reg     <= 1'b0;
            valid2_reg     <= 1'b0;
            valid3_reg     <= 1'b0;
            valid4_reg     <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            if (ready0)
                valid0_reg <= in_valid;
            if (ready1)
                valid1_reg <= valid0_reg;
            if (ready2)
                valid2_reg <= valid1_reg;
            if (ready3)
                valid3_reg <= valid2_reg;
            if (ready4)
                valid4_reg <= valid3_reg;
            if (accept)
                last_error_reg <= (cmd == pidc_pkg::CMD_CLEAR) ? '0 : error_sample;
        end
    end

    assign error_ext = {error_sample[DATA_WIDTH-1], error_sample};
    assign last_ext  = {last_error_reg[DATA_WIDTH-1], last_error_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clear0_reg <= (cmd == pidc_pkg::CMD_CLEAR);
            err0_reg   <= error_ext;
            sum0_reg   <= error_ext + last_ext;
            diff0_reg  <= error_ext - last_ext;
        end
        if (ready1 && valid0_reg)
            clear1_reg <= clear0_reg;
        if (ready2 && valid1_reg)
            clear2_reg <= clear1_reg;
        if (ready3 && valid2_reg)
        begin
            clear3_reg <= clear2_reg;
            pd3_reg    <= prop_term + deriv_term;
        end
    end

    assign term_ctrl.load_mul   = ready1 && valid0_reg;
    assign term_ctrl.load_scale = ready2 && valid1_reg;

    pidc_term #(
        .DATA_WIDTH (DATA_WIDTH),
        .SHIFT      (FRAC_BITS)
    ) u_prop (
        .clk     (clk),
        .ctrl    (term_ctrl),
        .operand (err0_reg),
        .gain    (prop_gain_reg),
        .term    (prop_term)
    );

    // the halving of the trapezoid rides in the extra shift bit
    pidc_term #(
        .DATA_WIDTH (DATA_WIDTH),
        .SHIFT      (FRAC_BITS + 1)
    ) u_step (
        .clk     (clk),
        .ctrl    (term_ctrl),
        .operand (sum0_reg),
        .gain    (integ_gain_reg),
        .term    (step_term)
    );

    pidc_term #(
        .DATA_WIDTH (DATA_WIDTH),
        .SHIFT      (FRAC_BITS)
    ) u_deriv (
        .clk     (clk),
        .ctrl    (term_ctrl),
        .operand (diff0_reg),
        .gain    (deriv_gain_reg),
        .term    (deriv_term)
    );

    // cap each limit so the clamped value fits the data width
    assign integ_lim_raw  = $signed(pidc_pkg::TERM_W'({1'b0, integral_limit_reg}));
    assign output_lim_raw = $signed(pidc_pkg::TERM_W'({1'b0, output_limit_reg}));
    assign integ_lim      = (integ_lim_raw > DATA_MAX) ? DATA_MAX : integ_lim_raw;
    assign output_lim     = (output_lim_raw > DATA_MAX) ? DATA_MAX : output_lim_raw;

    pidc_integ #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_integ (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (ready3 && valid2_reg),
        .clear (clear2_reg),
        .step  (step_term),
        .limit (integ_lim),
        .integ (integ_val),
        .hit   (integ_hit)
    );

    assign total         = pd3_reg + integ_val;
    assign total_clamped = pidc_pkg::clamp_sym(total, output_lim);

    always_ff @(posedge clk)
    begin
        if (ready4 && valid3_reg)
        begin
            drive_reg <= clear3_reg ? '0 : total_clamped.value[DATA_WIDTH-1:0];
            iflag_reg <= clear3_reg ? 1'b0 : integ_hit;
            oflag_reg <= clear3_reg ? 1'b0 : total_clamped.hit;
        end
    end

    assign out_valid        = valid4_reg;
    assign drive_value      = drive_reg;
    assign integral_clamped = iflag_reg;
    assign output_clamped   = oflag_reg;

endmodule

// ===== rtl/pidc_checker.sv =====
module pidc_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [DATA_WIDTH-1:0] drive_value
);

    // no result beat may be offered once reset has been applied
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result beat offered during reset");

    // input is held off only when the whole pipeline is blocked at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output is free");

    // a beat accepted into a free-running pipeline emerges at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            ##1 !out_stall |=> out_valid)
        else $error("result beat missing after pipeline latency");

    // a stalled result beat stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(drive_value)))
        else $error("stalled result beat dropped or changed");

endmodule

bind pid_controller_trapezoid_clamped pidc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pidc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_value (drive_value)
);
